[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FMP_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FMP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/fmp_pkg.sv]
// Types and constants shared by the Firmata message parser modules.
`default_nettype none

package fmp_pkg;

   // Status byte values of the protocol.
   localparam logic [7:0] STATUS_ANALOG      = 8'hE0;
   localparam logic [7:0] STATUS_DIGITAL     = 8'h90;
   localparam logic [7:0] STATUS_PIN_MODE    = 8'hF4;
   localparam logic [7:0] STATUS_REP_ANALOG  = 8'hC0;
   localparam logic [7:0] STATUS_REP_DIGITAL = 8'hD0;
   localparam logic [7:0] STATUS_SYSEX_START = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_END   = 8'hF7;
   localparam logic [7:0] STATUS_RESET       = 8'hFF;
   localparam logic [7:0] STATUS_VERSION     = 8'hF9;
   localparam logic [7:0] STATUS_SYSTEM      = 8'hF0;
   localparam logic [7:0] CMD_MASK           = 8'hF0;

   // Command class found by the front end.
   typedef logic [3:0] cmd_type;
   localparam cmd_type CMD_NONE        = 4'd0;
   localparam cmd_type CMD_ANALOG      = 4'd1;
   localparam cmd_type CMD_DIGITAL     = 4'd2;
   localparam cmd_type CMD_REP_ANALOG  = 4'd3;
   localparam cmd_type CMD_REP_DIGITAL = 4'd4;
   localparam cmd_type CMD_PIN_MODE    = 4'd5;
   localparam cmd_type CMD_SYSEX       = 4'd6;
   localparam cmd_type CMD_RESET       = 4'd7;
   localparam cmd_type CMD_VERSION     = 4'd8;

   // Message waiting for its data bytes.
   typedef logic [2:0] pend_type;
   localparam pend_type PEND_NONE        = 3'd0;
   localparam pend_type PEND_ANALOG      = 3'd1;
   localparam pend_type PEND_DIGITAL     = 3'd2;
   localparam pend_type PEND_REP_ANALOG  = 3'd3;
   localparam pend_type PEND_REP_DIGITAL = 3'd4;
   localparam pend_type PEND_PIN_MODE    = 3'd5;

   // Result kinds.
   typedef logic [3:0] kind_type;
   localparam kind_type KIND_ANALOG      = 4'd0;
   localparam kind_type KIND_DIGITAL     = 4'd1;
   localparam kind_type KIND_REP_ANALOG  = 4'd2;
   localparam kind_type KIND_REP_DIGITAL = 4'd3;
   localparam kind_type KIND_PIN_MODE    = 4'd4;
   localparam kind_type KIND_SYSEX_BYTE  = 4'd5;
   localparam kind_type KIND_SYSEX_END   = 4'd6;
   localparam kind_type KIND_SYSEX_EMPTY = 4'd7;
   localparam kind_type KIND_RESET       = 4'd8;
   localparam kind_type KIND_VERSION     = 4'd9;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 48;

   // One classified byte as it travels from the front end to the back end.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_data;
      logic       is_end;
      logic       sets_channel;
      cmd_type    cmd;
   } beat_type;

   // One parsed result.
   typedef struct packed {
      kind_type   kind;
      logic [3:0] channel;
      logic [13:0] value;
      logic [6:0] pin;
      logic [6:0] sysex_index;
      logic [7:0] sysex_command;
      logic       overflow;
   } result_type;

endpackage

`default_nettype wire

[hdl/fmp_front.sv]
// Front end: accepts received bytes and classifies them into command classes.
`default_nettype none

module fmp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   output logic                   push,
   output fmp_pkg::beat_type      push_beat,
   input  wire logic              queue_full
);
   import fmp_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff, beat_in;
   beat_type classified;
   logic [7:0] status;
   logic     accept;

   always_comb begin
      status = (req_tdata < STATUS_SYSTEM) ? (req_tdata & CMD_MASK) : req_tdata;
      classified.data_byte    = req_tdata;
      classified.is_data      = ~req_tdata[7];
      classified.is_end       = (req_tdata == STATUS_SYSEX_END);
      classified.sets_channel = (req_tdata < STATUS_SYSTEM);
      case (status)
         STATUS_ANALOG:      classified.cmd = CMD_ANALOG;
         STATUS_DIGITAL:     classified.cmd = CMD_DIGITAL;
         STATUS_PIN_MODE:    classified.cmd = CMD_PIN_MODE;
         STATUS_REP_ANALOG:  classified.cmd = CMD_REP_ANALOG;
         STATUS_REP_DIGITAL: classified.cmd = CMD_REP_DIGITAL;
         STATUS_SYSEX_START: classified.cmd = CMD_SYSEX;
         STATUS_RESET:       classified.cmd = CMD_RESET;
         STATUS_VERSION:     classified.cmd = CMD_VERSION;
         default:            classified.cmd = CMD_NONE;
      endcase
   end

   assign req_tready = ~valid_ff | ~queue_full;
   assign accept     = req_tvalid & req_tready;
   assign push       = valid_ff & ~queue_full;
   assign push_beat  = beat_ff;

   always_comb begin
      valid_in = accept | (valid_ff & queue_full);
      beat_in  = accept ? classified : beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

endmodule

`default_nettype wire

[hdl/fmp_queue.sv]
// Short queue of classified beats between the front end and the back end.
`default_nettype none

module fmp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  fmp_pkg::beat_type      push_beat,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output fmp_pkg::beat_type      pop_beat
);
   import fmp_pkg::*;

   beat_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_beat  = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

`default_nettype wire

[hdl/fmp_back.sv]
// Back end: parser state, message assembly and the result register.
`default_nettype none

module fmp_back #(
   parameter int MAX_SYSEX_BYTES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beat_valid,
   input  fmp_pkg::beat_type      beat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fmp_pkg::result_type    rsp_result
);
   import fmp_pkg::*;

   localparam int CNT_W = $clog2(MAX_SYSEX_BYTES + 1);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SYSEX_BYTES);
   localparam logic [6:0] MAX_INDEX = 7'(MAX_SYSEX_BYTES % 128);

   logic             in_sysex_ff, in_sysex_in;
   logic [1:0]       remaining_ff, remaining_in;
   pend_type         pending_ff, pending_in;
   logic [3:0]       channel_ff, channel_in;
   logic [6:0]       first_data_ff, first_data_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sysex_first_ff, sysex_first_in;
   logic             overflowed_ff, overflowed_in;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;
   result_type       res;
   logic             emit;
   logic             take;
   logic [1:0]       remaining_dec;

   assign take       = beat_valid & (~out_valid_ff | rsp_ready);
   assign pop        = take;
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   always_comb begin
      in_sysex_in    = in_sysex_ff;
      remaining_in   = remaining_ff;
      pending_in     = pending_ff;
      channel_in     = channel_ff;
      first_data_in  = first_data_ff;
      count_in       = count_ff;
      sysex_first_in = sysex_first_ff;
      overflowed_in  = overflowed_ff;
      remaining_dec  = remaining_ff - 2'd1;
      emit           = 1'b0;
      res            = '0;

      if (take) begin
         if (in_sysex_ff) begin
            emit = 1'b1;
            if (beat.is_end) begin
               in_sysex_in = 1'b0;
               if (count_ff == '0) begin
                  res.kind = KIND_SYSEX_EMPTY;
               end else begin
                  res.kind          = KIND_SYSEX_END;
                  res.sysex_index   = 7'(count_ff - CNT_W'(1));
                  res.sysex_command = sysex_first_ff;
                  res.overflow      = overflowed_ff;
               end
            end else if (count_ff < MAX_COUNT) begin
               if (count_ff == '0) begin
                  sysex_first_in = beat.data_byte;
               end
               count_in        = count_ff + CNT_W'(1);
               res.kind        = KIND_SYSEX_BYTE;
               res.value       = 14'(beat.data_byte);
               res.sysex_index = 7'(count_ff);
               res.overflow    = overflowed_ff;
            end else begin
               overflowed_in   = 1'b1;
               res.kind        = KIND_SYSEX_BYTE;
               res.value       = 14'(beat.data_byte);
               res.sysex_index = MAX_INDEX;
               res.overflow    = 1'b1;
            end
         end else if ((remaining_ff != 2'd0) && beat.is_data) begin
            remaining_in = remaining_dec;
            if (remaining_dec != 2'd0) begin
               first_data_in = beat.data_byte[6:0];
            end else if (pending_ff != PEND_NONE) begin
               pending_in = PEND_NONE;
               emit       = 1'b1;
               case (pending_ff)
                  PEND_ANALOG: begin
                     res.kind  = KIND_ANALOG;
                     res.value = {beat.data_byte[6:0], first_data_ff};
                  end
                  PEND_DIGITAL: begin
                     res.kind  = KIND_DIGITAL;
                     res.value = {beat.data_byte[6:0], first_data_ff};
                  end
                  PEND_REP_ANALOG: begin
                     res.kind  = KIND_REP_ANALOG;
                     res.value = 14'(beat.data_byte);
                  end
                  PEND_REP_DIGITAL: begin
                     res.kind  = KIND_REP_DIGITAL;
                     res.value = 14'(beat.data_byte);
                  end
                  PEND_PIN_MODE: begin
                     res.kind  = KIND_PIN_MODE;
                     res.value = 14'(beat.data_byte);
                     res.pin   = first_data_ff;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end else begin
            if (beat.sets_channel) begin
               channel_in = beat.data_byte[3:0];
            end
            case (beat.cmd)
               CMD_ANALOG: begin
                  remaining_in = 2'd2;
                  pending_in   = PEND_ANALOG;
               end
               CMD_DIGITAL: begin
                  remaining_in = 2'd2;
                  pending_in   = PEND_DIGITAL;
               end
               CMD_PIN_MODE: begin
                  remaining_in = 2'd2;
                  pending_in   = PEND_PIN_MODE;
               end
               CMD_REP_ANALOG: begin
                  remaining_in = 2'd1;
                  pending_in   = PEND_REP_ANALOG;
               end
               CMD_REP_DIGITAL: begin
                  remaining_in = 2'd1;
                  pending_in   = PEND_REP_DIGITAL;
               end
               CMD_SYSEX: begin
                  in_sysex_in    = 1'b1;
                  count_in       = '0;
                  sysex_first_in = '0;
                  overflowed_in  = 1'b0;
               end
               CMD_RESET: begin
                  in_sysex_in    = 1'b0;
                  remaining_in   = 2'd0;
                  pending_in     = PEND_NONE;
                  channel_in     = 4'd0;
                  first_data_in  = 7'd0;
                  count_in       = '0;
                  sysex_first_in = 8'd0;
                  overflowed_in  = 1'b0;
                  emit           = 1'b1;
                  res.kind       = KIND_RESET;
               end
               CMD_VERSION: begin
                  emit     = 1'b1;
                  res.kind = KIND_VERSION;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
         end
      end
      // The channel reported is the one in force after this byte.
      res.channel = channel_in;

      out_valid_in = out_valid_ff & ~rsp_ready;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sysex_ff    <= 1'b0;
         remaining_ff   <= 2'd0;
         pending_ff     <= PEND_NONE;
         channel_ff     <= 4'd0;
         first_data_ff  <= 7'd0;
         count_ff       <= '0;
         sysex_first_ff <= 8'd0;
         overflowed_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         in_sysex_ff    <= in_sysex_in;
         remaining_ff   <= remaining_in;
         pending_ff     <= pending_in;
         channel_ff     <= channel_in;
         first_data_ff  <= first_data_in;
         count_ff       <= count_in;
         sysex_first_ff <= sysex_first_in;
         overflowed_ff  <= overflowed_in;
         out_valid_ff   <= out_valid_in;
      end
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

[hdl/firmata_message_parser.sv]
// Top level of the Firmata message parser: front end, queue and back end.
`default_nettype none

// The parser takes one received serial byte per beat on the req_ channel and
// returns at most one parsed message per byte on the rsp_ channel. Analog and
// digital messages, report commands, set pin mode, system reset and report
// version each give one result when complete; every byte inside a sysex frame
// gives one result, and the end marker gives a summary with the first sysex
// byte and the index of the last one, or marks an empty frame. Bytes that
// only set state give no result. An accepted byte is registered in the
// classifying front end, is written into the four-beat queue, and reaches the
// back end, which updates the parser state and loads the result register that
// drives rsp_tvalid. Throughput is one byte per cycle while rsp_tready stays
// high; the back end updates the parser state as it takes each beat. When
// the receiver holds rsp_tready low the result register holds its beat, the
// back end stops taking beats, the queue fills, and req_tready falls only
// once the queue and the front register are full. Reset clears the parser
// state, empties the queue and drops any result not yet taken; a system
// reset byte outside a sysex frame clears the parser state the same way and
// reports channel zero.

module firmata_message_parser #(
   parameter int MAX_SYSEX_BYTES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] channel, [17:4] value, [24:18] pin, [31:25] sysex_index,
   // [39:32] sysex_command, [40] overflow, [47:41] zero
   output logic [47:0]      rsp_tdata,
   output logic [3:0]       rsp_tuser   // [3:0] kind
);
   import fmp_pkg::*;

   logic       front_push;
   beat_type   front_beat;
   logic       queue_full;
   logic       queue_valid;
   beat_type   queue_beat;
   logic       back_pop;
   result_type result;

   fmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (front_push),
      .push_beat  (front_beat),
      .queue_full (queue_full)
   );

   fmp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_beat (front_beat),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_valid (queue_valid),
      .pop_beat  (queue_beat)
   );

   fmp_back #(
      .MAX_SYSEX_BYTES (MAX_SYSEX_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (queue_valid),
      .beat       (queue_beat),
      .pop        (back_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // The kind says what the beat holds, so it rides on tuser; everything else
   // is packed into tdata from the lowest bit up.
   assign rsp_tuser = result.kind;
   assign rsp_tdata = {7'd0, result.overflow, result.sysex_command, result.sysex_index,
                       result.pin, result.value, result.channel};

endmodule

`default_nettype wire

[hdl/fmp_checker.sv]
// Port-level checker for the Firmata message parser and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module fmp_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [fmp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic [3:0]                      rsp_tuser
);
   import fmp_pkg::*;

   logic                  stalled;
   logic [RSP_DATA_W+4:0] rsp_beat;
   logic                  is_reset;
   logic                  is_sysex;
   logic                  is_pin;
   logic [7:0]            sysex_bits;
   logic [13:0]           pin_bits;

   assign stalled    = rsp_tvalid && !rsp_tready;
   assign rsp_beat   = {rsp_tvalid, rsp_tuser, rsp_tdata};
   assign is_reset   = (rsp_tuser == KIND_RESET);
   assign is_sysex   = (rsp_tuser == KIND_SYSEX_BYTE) || (rsp_tuser == KIND_SYSEX_END);
   assign is_pin     = (rsp_tuser == KIND_PIN_MODE);
   assign sysex_bits = {rsp_tdata[40], rsp_tdata[31:25]};
   assign pin_bits   = {rsp_tdata[47:41], rsp_tdata[24:18]};

   // A stalled result beat keeps its contents.
   `FMP_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_beat))

   // A system reset message always reports channel zero.
   `FMP_ASSERT_IMPL(a_reset_channel, clock, reset, rsp_tvalid && is_reset, rsp_tdata[3:0] == 4'd0)

   // Only sysex beats carry the overflow flag or an index.
   `FMP_ASSERT_IMPL(a_sysex_fields, clock, reset, rsp_tvalid && !is_sysex, sysex_bits == 8'd0)

   // A pin number only comes with set pin mode, and on other beats the padding stays zero.
   `FMP_ASSERT_IMPL(a_pin_field, clock, reset, rsp_tvalid && !is_pin, pin_bits == 14'd0)

endmodule

bind firmata_message_parser fmp_checker u_fmp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
